FILE: rtl/pafl_pkg.sv
// Shared constants, codes and state type for the per-floor polygon area block.
`default_nettype none

package pafl_pkg;

  // Sizing of the floor table and coordinates
  localparam int MAX_FLOORS = 16;
  localparam int COORD_BITS = 24;
  localparam int FLOOR_AW   = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;

  // Fixed field widths
  localparam int FLOOR_W = 8;
  localparam int CNT_W   = 5;
  localparam int AREA_W  = 63;
  localparam int SUM_W   = 64;
  localparam int YSUM_W  = COORD_BITS + 1;
  localparam int TERM_W  = 2 * COORD_BITS + 2;

  // Saturation limits
  localparam logic [AREA_W-1:0]     AREA_MAX = {AREA_W{1'b1}};
  localparam logic signed [SUM_W:0] SUM_MAX  = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_MIN  = -SUM_MAX;

  // Reset value of the floor count register
  localparam logic [CNT_W-1:0] FLOOR_COUNT_RST = CNT_W'(16);

  // Input operation codes
  localparam logic OP_VERTEX   = 1'b0;
  localparam logic OP_END_PASS = 1'b1;

  // Result kinds
  localparam logic KIND_AREA  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CLOSE,
    ST_FETCH,
    ST_UPDATE,
    ST_EMIT,
    ST_RPT_RD,
    ST_RPT_EMIT
  } pafl_state_t;

endpackage

`default_nettype wire

FILE: rtl/polygon_area_per_floor.sv
// Top level: shoelace polygon area with saturating per-floor totals.
//
// Usage:
//   Input channel (in_*): one beat per vertex, or one end-of-pass beat
//   (in_operation = end of pass). Vertices are signed Q15.8; the floor is
//   taken from a polygon's first vertex; in_last_vertex closes the polygon.
//   Result channel (out_*): one area beat per closed polygon, and one total
//   beat per kept floor on end of pass, last_result set on the final one.
//   Config: cfg_wr_en/cfg_wr_data write floor_count; write only when idle.
// Sequencing:
//   A first vertex that is not last only opens the polygon; any other
//   non-closing vertex passes operand setup, multiply and saturating accumulate.
//   A closing vertex runs its edge terms through the one shared multiplier,
//   then a read-modify-write of the floor total RAM; its area beat is then
//   loaded into the output register. End of pass reads one kept floor at a
//   time through the single RAM read port and emits its total beat.
// Reset and stall:
//   Reset clears all floor totals at once through per-floor valid bits.
//   The result is held in an output register; a stalled receiver only
//   blocks the sequencer once a second result is ready to load.
`default_nettype none

module polygon_area_per_floor
  import pafl_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_operation,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_y,
  input  wire logic        [FLOOR_W-1:0]    in_floor_number,
  input  wire logic                         in_last_vertex,
  // Result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_result_kind,
  output logic             [FLOOR_W-1:0]    out_floor_id,
  output logic             [AREA_W-1:0]     out_area_value,
  output logic                              out_counted,
  output logic                              out_last_result,
  // Configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic        [CNT_W-1:0]      cfg_wr_data
);

  pafl_state_t state_r, state_nxt;

  // Control state
  logic                  in_poly_r;
  logic                  close_r;
  logic                  final_r;
  logic [MAX_FLOORS-1:0] valid_r;
  logic [FLOOR_AW-1:0]   rpt_idx_r;
  logic [CNT_W-1:0]      floor_count_r;
  logic                  out_valid_r;

  // Datapath registers
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic        [FLOOR_W-1:0]    poly_floor_r;
  logic signed [YSUM_W-1:0]     ysum_r, xdif_r;
  logic signed [TERM_W-1:0]     term_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic        [AREA_W-1:0]     mag_r;
  logic                         rd_valid_r;

  // Output payload registers
  logic                out_kind_r;
  logic [FLOOR_W-1:0]  out_floor_r;
  logic [AREA_W-1:0]   out_area_r;
  logic                out_counted_r;
  logic                out_last_r;

  // Combinational controls
  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                ram_rd_en;
  logic                ram_wr_en;
  logic [FLOOR_AW-1:0] ram_rd_addr;
  logic [AREA_W-1:0]   ram_rd_data;

  // Combinational datapath
  logic        [FLOOR_W-1:0]  kept_c;
  logic                       counted_c;
  logic                       rpt_last_c;
  logic                       kept_zero_c;
  logic signed [TERM_W-1:0]   prod_c;
  logic signed [SUM_W:0]      acc_wide_c;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic        [AREA_W-1:0]   mag_nxt;
  logic        [AREA_W-1:0]   tot_eff_c;
  logic        [AREA_W:0]     tot_wide_c;
  logic        [AREA_W-1:0]   tot_nxt;

  // Floors kept: floor_count capped at the table size
  assign kept_c = (FLOOR_W'(floor_count_r) > FLOOR_W'(MAX_FLOORS)) ?
                  FLOOR_W'(MAX_FLOORS) : FLOOR_W'(floor_count_r);
  assign kept_zero_c = (kept_c == '0);
  assign counted_c   = (poly_floor_r < kept_c);
  assign rpt_last_c  = ((FLOOR_W'(rpt_idx_r) + FLOOR_W'(1)) == kept_c);

  // Edge term and saturating accumulate
  assign prod_c     = ysum_r * xdif_r;
  assign acc_wide_c = (SUM_W+1)'(sum_r) + (SUM_W+1)'(term_r);
  always_comb begin
    if (acc_wide_c > SUM_MAX) begin
      sum_nxt = SUM_MAX[SUM_W-1:0];
    end else if (acc_wide_c < SUM_MIN) begin
      sum_nxt = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_nxt = acc_wide_c[SUM_W-1:0];
    end
  end

  // Magnitude of the closed sum, fits 63 bits after saturation
  assign mag_nxt = sum_r[SUM_W-1] ? AREA_W'(-sum_r) : sum_r[AREA_W-1:0];

  // Floor total update, unwritten entries read as zero
  assign tot_eff_c  = rd_valid_r ? ram_rd_data : '0;
  assign tot_wide_c = {1'b0, tot_eff_c} + {1'b0, mag_r};
  assign tot_nxt    = tot_wide_c[AREA_W] ? AREA_MAX : tot_wide_c[AREA_W-1:0];

  // Handshake
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_END_PASS) begin
            state_nxt = kept_zero_c ? ST_IDLE : ST_RPT_RD;
          end else if (!in_poly_r) begin
            state_nxt = in_last_vertex ? ST_CLOSE : ST_IDLE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL:    state_nxt = ST_ACC;
      ST_ACC: begin
        if (close_r) begin
          state_nxt = ST_CLOSE;
        end else if (final_r) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLOSE:  state_nxt = ST_MUL;
      ST_FETCH:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_EMIT;
      ST_EMIT:   state_nxt = out_free ? ST_IDLE : ST_EMIT;
      ST_RPT_RD: state_nxt = ST_RPT_EMIT;
      ST_RPT_EMIT: begin
        if (out_free) begin
          state_nxt = rpt_last_c ? ST_IDLE : ST_RPT_RD;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall    = 1'b1;
    ram_rd_en   = 1'b0;
    ram_rd_addr = rpt_idx_r;
    ram_wr_en   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE:     in_stall = 1'b0;
      ST_FETCH: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = poly_floor_r[FLOOR_AW-1:0];
      end
      ST_UPDATE:   ram_wr_en = counted_c;
      ST_EMIT:     out_load  = out_free;
      ST_RPT_RD:   ram_rd_en = 1'b1;
      ST_RPT_EMIT: out_load  = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      in_poly_r     <= 1'b0;
      close_r       <= 1'b0;
      final_r       <= 1'b0;
      valid_r       <= '0;
      rpt_idx_r     <= '0;
      floor_count_r <= FLOOR_COUNT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        floor_count_r <= cfg_wr_data;
      end
      // Open a polygon or mark a pending closing edge
      if (in_acc && in_operation == OP_VERTEX) begin
        if (!in_poly_r) begin
          in_poly_r <= 1'b1;
        end else begin
          close_r <= in_last_vertex;
        end
      end
      // Start of an end-of-pass report
      if (in_acc && in_operation == OP_END_PASS) begin
        rpt_idx_r <= '0;
        if (kept_zero_c) begin
          valid_r <= '0;
        end
      end
      if (state_r == ST_CLOSE) begin
        close_r <= 1'b0;
        final_r <= 1'b1;
      end
      if (state_r == ST_FETCH) begin
        final_r   <= 1'b0;
        in_poly_r <= 1'b0;
      end
      if (ram_wr_en) begin
        valid_r[poly_floor_r[FLOOR_AW-1:0]] <= 1'b1;
      end
      // Advance the report, clear totals after its last beat
      if (state_r == ST_RPT_EMIT && out_load) begin
        if (rpt_last_c) begin
          valid_r <= '0;
        end else begin
          rpt_idx_r <= rpt_idx_r + FLOOR_AW'(1);
        end
      end
      // Output register valid
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_VERTEX) begin
      prev_x_r <= in_vertex_x;
      prev_y_r <= in_vertex_y;
      ysum_r   <= YSUM_W'(prev_y_r) + YSUM_W'(in_vertex_y);
      xdif_r   <= YSUM_W'(in_vertex_x) - YSUM_W'(prev_x_r);
      if (!in_poly_r) begin
        first_x_r    <= in_vertex_x;
        first_y_r    <= in_vertex_y;
        poly_floor_r <= in_floor_number;
        sum_r        <= '0;
      end
    end
    // Closing edge back to the first vertex
    if (state_r == ST_CLOSE) begin
      ysum_r <= YSUM_W'(prev_y_r) + YSUM_W'(first_y_r);
      xdif_r <= YSUM_W'(first_x_r) - YSUM_W'(prev_x_r);
    end
    if (state_r == ST_MUL) begin
      term_r <= prod_c;
    end
    if (state_r == ST_ACC) begin
      sum_r <= sum_nxt;
    end
    if (state_r == ST_FETCH) begin
      mag_r <= mag_nxt;
    end
    if (ram_rd_en) begin
      rd_valid_r <= valid_r[ram_rd_addr];
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == ST_RPT_EMIT) begin
        out_kind_r    <= KIND_TOTAL;
        out_floor_r   <= FLOOR_W'(rpt_idx_r);
        out_area_r    <= tot_eff_c;
        out_counted_r <= 1'b0;
        out_last_r    <= rpt_last_c;
      end else begin
        out_kind_r    <= KIND_AREA;
        out_floor_r   <= poly_floor_r;
        out_area_r    <= mag_r;
        out_counted_r <= counted_c;
        out_last_r    <= 1'b0;
      end
    end
  end

  // Floor totals
  pafl_ram #(
    .WIDTH (AREA_W),
    .DEPTH (MAX_FLOORS)
  ) u_totals (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (poly_floor_r[FLOOR_AW-1:0]),
    .wr_data (tot_nxt),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_floor_id    = out_floor_r;
  assign out_area_value  = out_area_r;
  assign out_counted     = out_counted_r;
  assign out_last_result = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/pafl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module pafl_ram #(
  parameter int  WIDTH = 63,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pafl_chk.sv
// Port-level checker for the per-floor polygon area block, bound to the top level.
`default_nettype none

module pafl_chk
  import pafl_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_result_kind,
  input wire logic [FLOOR_W-1:0] out_floor_id,
  input wire logic [AREA_W-1:0]  out_area_value,
  input wire logic               out_counted,
  input wire logic               out_last_result
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_area_value) &&
    $stable(out_floor_id) && $stable(out_result_kind))
    else $error("result beat changed while stalled");

  // An area beat never ends a report run
  a_area_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_AREA |-> !out_last_result)
    else $error("area beat flagged as last total");

  // Totals never carry the counted flag
  a_total_not_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_TOTAL |-> !out_counted)
    else $error("floor total flagged as counted");

  // Only floors inside the table are counted or reported
  a_floor_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_counted || out_result_kind == KIND_TOTAL) |->
    out_floor_id < FLOOR_W'(MAX_FLOORS))
    else $error("floor index outside the table");

endmodule

bind polygon_area_per_floor pafl_chk u_pafl_chk (.*);

`default_nettype wire
